/* sv/bsc_pkg.sv */
package bsc_pkg;

   localparam int FUNC_W      = 2;
   localparam int PROC_IDX_W  = 4;
   localparam int RES_IDX_W   = 3;
   localparam int AMOUNT_W    = 10;
   localparam int FREE_W      = 16;
   localparam int PICK_W      = 4;
   localparam int PC_CFG_W    = 5;
   localparam int RC_CFG_W    = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [PC_CFG_W-1:0] PC_CFG_RESET = 5'd16;
   localparam logic [RC_CFG_W-1:0] RC_CFG_RESET = 4'd8;
   localparam logic [FREE_W-1:0]   FREE_LIMIT   = 16'hffff;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESOURCE_COUNT = 2'd1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_ALLOC = 2'd0,
      FUNC_LOAD_CLAIM = 2'd1,
      FUNC_LOAD_FREE  = 2'd2,
      FUNC_CHECK      = 2'd3
   } func_type;

   typedef struct packed {
      logic              fail;
      logic [FREE_W-1:0] sum;
   } alu_res_type;

endpackage

/* sv/bsc_req_if.sv */
interface bsc_req_if;
   logic                           valid;
   logic                           ready;
   logic [bsc_pkg::FUNC_W-1:0]     func;
   logic [bsc_pkg::PROC_IDX_W-1:0] process_index;
   logic [bsc_pkg::RES_IDX_W-1:0]  resource_index;
   logic [bsc_pkg::AMOUNT_W-1:0]   amount;

   modport source (output valid, func, process_index, resource_index, amount, input ready);
   modport sink (input valid, func, process_index, resource_index, amount, output ready);
endinterface

/* sv/bsc_rsp_if.sv */
interface bsc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bsc_pkg::PICK_W-1:0] picked_process;
   logic                       is_verdict;
   logic                       system_safe;
   logic                       last_of_run;

   modport source (output valid, picked_process, is_verdict, system_safe, last_of_run,
                   input ready);
   modport sink (input valid, picked_process, is_verdict, system_safe, last_of_run,
                 output ready);
endinterface

/* sv/bsc_csr_if.sv */
interface bsc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bsc_pkg::CSR_INDEX_W-1:0] index;
   logic [bsc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/bsc_ram.sv */
module bsc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bsc_alu.sv */
module bsc_alu (
   input  logic [bsc_pkg::AMOUNT_W-1:0] claim,
   input  logic [bsc_pkg::AMOUNT_W-1:0] alloc,
   input  logic [bsc_pkg::FREE_W-1:0]   free_amt,
   output bsc_pkg::alu_res_type         res
);

   logic [bsc_pkg::AMOUNT_W:0] diff;
   logic [bsc_pkg::FREE_W:0]   sum_full;

   // need is claim minus alloc; a negative need always fits
   assign diff     = {1'b0, claim} - {1'b0, alloc};
   assign res.fail = !diff[bsc_pkg::AMOUNT_W] &&
                     (bsc_pkg::FREE_W'(diff[bsc_pkg::AMOUNT_W-1:0]) > free_amt);

   assign sum_full = {1'b0, free_amt} + (bsc_pkg::FREE_W + 1)'(alloc);
   assign res.sum  = sum_full[bsc_pkg::FREE_W] ? bsc_pkg::FREE_LIMIT
                                               : sum_full[bsc_pkg::FREE_W-1:0];

endmodule

/* sv/bankers_safety_check_core.sv */
// channel  dir  handshake     payload
// req_bus  in   valid/ready   func, process_index, resource_index, amount
// rsp_bus  out  valid/ready   picked_process, is_verdict, system_safe, last_of_run
// csr_bus  in   valid/ready   index, data (always ready)
//
// a load transaction completes when it is accepted; req_bus is ready only while idle.
// a check scans rows from process 0, reading and comparing each resource of a row in turn;
// a pick reads and adds back each resource, then the scan restarts at row 0; every step
// goes through the single read port of the allocation and claim tables.
// each result waits in an output register; a stalled rsp_bus holds the sequencer.
// reset is synchronous and clears control state; the tables hold nothing until loaded.
module bankers_safety_check_core #(
   parameter int MAX_PROCESSES = 16,
   parameter int MAX_RESOURCES = 8
) (
   input logic         clock,
   input logic         reset,
   bsc_req_if.sink     req_bus,
   bsc_rsp_if.source   rsp_bus,
   bsc_csr_if.sink     csr_bus
);

   localparam int PCW   = $clog2(MAX_PROCESSES + 1);
   localparam int PIW   = MAX_PROCESSES > 1 ? $clog2(MAX_PROCESSES) : 1;
   localparam int RCW   = $clog2(MAX_RESOURCES + 1);
   localparam int RIW   = MAX_RESOURCES > 1 ? $clog2(MAX_RESOURCES) : 1;
   localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int BW    = $clog2(DEPTH + 1);
   localparam int PCFW  = PCW > bsc_pkg::PC_CFG_W ? PCW : bsc_pkg::PC_CFG_W;
   localparam int RCFW  = RCW > bsc_pkg::RC_CFG_W ? RCW : bsc_pkg::RC_CFG_W;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_ROW  = 7'b0000010,
      ST_RD   = 7'b0000100,
      ST_CMP  = 7'b0001000,
      ST_ARD  = 7'b0010000,
      ST_ADD  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [bsc_pkg::PC_CFG_W-1:0]   pc_cfg_ff, pc_cfg_in;
   logic [bsc_pkg::RC_CFG_W-1:0]   rc_cfg_ff, rc_cfg_in;
   logic [PCW-1:0]                 row_ff, row_in;
   logic [BW-1:0]                  base_ff, base_in;
   logic [RCW-1:0]                 col_ff, col_in;
   logic [PCW-1:0]                 total_ff, total_in;
   logic [MAX_PROCESSES-1:0]       flags_ff, flags_in;
   logic [bsc_pkg::FREE_W-1:0]     free_ff [MAX_RESOURCES];
   logic [bsc_pkg::FREE_W-1:0]     free_in [MAX_RESOURCES];
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bsc_pkg::PICK_W-1:0]     rsp_pick_ff, rsp_pick_in;
   logic                           rsp_verdict_ff, rsp_verdict_in;
   logic                           rsp_safe_ff, rsp_safe_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [PCW-1:0]                 pc;
   logic [RCW-1:0]                 rc;
   logic                           req_acc;
   logic                           csr_acc;
   bsc_pkg::func_type              load_func;
   logic                           proc_ok;
   logic                           res_ok;
   logic [AW-1:0]                  load_addr;
   logic [BW-1:0]                  scan_addr_full;
   logic [AW-1:0]                  scan_addr;
   logic [PIW-1:0]                 row_idx;
   logic [RIW-1:0]                 col_idx;
   logic                           col_last;
   logic                           pick_done;
   logic                           alloc_we;
   logic                           claim_we;
   logic                           clear_entry;
   logic [AW-1:0]                  wr_addr;
   logic [bsc_pkg::AMOUNT_W-1:0]   wr_data;
   logic [bsc_pkg::AMOUNT_W-1:0]   alloc_rd;
   logic [bsc_pkg::AMOUNT_W-1:0]   claim_rd;
   bsc_pkg::alu_res_type           alu_res;

   // counts above the maximum act as the maximum
   assign pc = (PCFW'(pc_cfg_ff) > PCFW'(MAX_PROCESSES)) ? PCW'(MAX_PROCESSES)
                                                          : PCW'(pc_cfg_ff);
   assign rc = (RCFW'(rc_cfg_ff) > RCFW'(MAX_RESOURCES)) ? RCW'(MAX_RESOURCES)
                                                          : RCW'(rc_cfg_ff);

   assign req_acc   = req_bus.valid && req_bus.ready;
   assign csr_acc   = csr_bus.valid && csr_bus.ready;
   assign load_func = bsc_pkg::func_type'(req_bus.func);
   assign proc_ok   = int'(req_bus.process_index) < MAX_PROCESSES;
   assign res_ok    = int'(req_bus.resource_index) < MAX_RESOURCES;
   assign load_addr = AW'(int'(req_bus.process_index) * MAX_RESOURCES +
                          int'(req_bus.resource_index));

   assign scan_addr_full = base_ff + BW'(col_ff);
   assign scan_addr      = scan_addr_full[AW-1:0];
   assign row_idx        = row_ff[PIW-1:0];
   assign col_idx        = col_ff[RIW-1:0];
   assign col_last       = (col_ff + RCW'(1)) == rc;

   assign clear_entry = state_ff == ST_ADD;
   assign wr_addr     = clear_entry ? scan_addr : load_addr;
   assign wr_data     = clear_entry ? '0 : req_bus.amount;

   bsc_ram #(
      .WIDTH (bsc_pkg::AMOUNT_W),
      .DEPTH (DEPTH)
   ) u_alloc_ram (
      .clock   (clock),
      .wr_en   (alloc_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_addr),
      .rd_data (alloc_rd)
   );

   bsc_ram #(
      .WIDTH (bsc_pkg::AMOUNT_W),
      .DEPTH (DEPTH)
   ) u_claim_ram (
      .clock   (clock),
      .wr_en   (claim_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_addr),
      .rd_data (claim_rd)
   );

   bsc_alu u_alu (
      .claim    (claim_rd),
      .alloc    (alloc_rd),
      .free_amt (free_ff[col_idx]),
      .res      (alu_res)
   );

   always_comb begin
      state_in       = state_ff;
      pc_cfg_in      = pc_cfg_ff;
      rc_cfg_in      = rc_cfg_ff;
      row_in         = row_ff;
      base_in        = base_ff;
      col_in         = col_ff;
      total_in       = total_ff;
      flags_in       = flags_ff;
      free_in        = free_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pick_in    = rsp_pick_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_safe_in    = rsp_safe_ff;
      rsp_last_in    = rsp_last_ff;
      alloc_we       = 1'b0;
      claim_we       = 1'b0;
      pick_done      = 1'b0;

      if (csr_acc) begin
         case (csr_bus.index)
            bsc_pkg::CSR_PROCESS_COUNT: pc_cfg_in = csr_bus.data[bsc_pkg::PC_CFG_W-1:0];
            bsc_pkg::CSR_RESOURCE_COUNT: rc_cfg_in = csr_bus.data[bsc_pkg::RC_CFG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (load_func)
                  bsc_pkg::FUNC_LOAD_ALLOC: alloc_we = proc_ok && res_ok;
                  bsc_pkg::FUNC_LOAD_CLAIM: claim_we = proc_ok && res_ok;
                  bsc_pkg::FUNC_LOAD_FREE: begin
                     if (res_ok) begin
                        free_in[RIW'(req_bus.resource_index)] =
                           bsc_pkg::FREE_W'(req_bus.amount);
                     end
                  end
                  bsc_pkg::FUNC_CHECK: begin
                     flags_in = '0;
                     total_in = '0;
                     row_in   = '0;
                     base_in  = '0;
                     state_in = ST_ROW;
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW: begin
            if (row_ff == pc) begin
               // scan ran off the end: nothing fits, or everyone is done
               rsp_valid_in   = 1'b1;
               rsp_pick_in    = '0;
               rsp_verdict_in = 1'b1;
               rsp_safe_in    = total_ff == pc;
               rsp_last_in    = 1'b1;
               state_in       = ST_OUT;
            end else if (flags_ff[row_idx]) begin
               row_in  = row_ff + PCW'(1);
               base_in = base_ff + BW'(MAX_RESOURCES);
            end else if (rc == '0) begin
               pick_done = 1'b1;
            end else begin
               col_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (alu_res.fail) begin
               row_in   = row_ff + PCW'(1);
               base_in  = base_ff + BW'(MAX_RESOURCES);
               state_in = ST_ROW;
            end else if (col_last) begin
               col_in   = '0;
               state_in = ST_ARD;
            end else begin
               col_in   = col_ff + RCW'(1);
               state_in = ST_RD;
            end
         end
         ST_ARD: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // hand the allocation back and zero both table entries
            free_in[col_idx] = alu_res.sum;
            alloc_we         = 1'b1;
            claim_we         = 1'b1;
            if (col_last) begin
               pick_done = 1'b1;
            end else begin
               col_in   = col_ff + RCW'(1);
               state_in = ST_ARD;
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_verdict_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = '0;
                  base_in  = '0;
                  state_in = ST_ROW;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pick_done) begin
         flags_in[row_idx] = 1'b1;
         total_in          = total_ff + PCW'(1);
         rsp_valid_in      = 1'b1;
         rsp_pick_in       = bsc_pkg::PICK_W'(row_ff);
         rsp_verdict_in    = 1'b0;
         rsp_safe_in       = 1'b0;
         rsp_last_in       = 1'b0;
         state_in          = ST_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_cfg_ff    <= bsc_pkg::PC_CFG_RESET;
         rc_cfg_ff    <= bsc_pkg::RC_CFG_RESET;
         total_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_cfg_ff    <= pc_cfg_in;
         rc_cfg_ff    <= rc_cfg_in;
         total_ff     <= total_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      base_ff        <= base_in;
      col_ff         <= col_in;
      free_ff        <= free_in;
      rsp_pick_ff    <= rsp_pick_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_safe_ff    <= rsp_safe_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_bus.ready          = state_ff == ST_IDLE;
   assign csr_bus.ready          = 1'b1;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.picked_process = rsp_pick_ff;
   assign rsp_bus.is_verdict     = rsp_verdict_ff;
   assign rsp_bus.system_safe    = rsp_safe_ff;
   assign rsp_bus.last_of_run    = rsp_last_ff;

endmodule

/* tb/tb_bankers_safety_check_core.sv */
`timescale 1ns / 1ps

module tb_bankers_safety_check_core;

   localparam int N_PROC       = 16;
   localparam int N_RES        = 8;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int PHASE_ITEMS  = 30;

   typedef struct packed {
      logic [bsc_pkg::PICK_W-1:0] picked_process;
      logic                       is_verdict;
      logic                       system_safe;
      logic                       last_of_run;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset;

   bsc_req_if req_bus ();
   bsc_rsp_if rsp_bus ();
   bsc_csr_if csr_bus ();

   bankers_safety_check_core #(
      .MAX_PROCESSES (N_PROC),
      .MAX_RESOURCES (N_RES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // shadow of the block state
   logic [bsc_pkg::AMOUNT_W-1:0] alloc_shadow [N_PROC][N_RES];
   logic [bsc_pkg::AMOUNT_W-1:0] claim_shadow [N_PROC][N_RES];
   logic [bsc_pkg::FREE_W-1:0]   free_shadow  [N_RES];
   logic [bsc_pkg::PC_CFG_W-1:0] proc_count_cfg = bsc_pkg::PC_CFG_RESET;
   logic [bsc_pkg::RC_CFG_W-1:0] res_count_cfg  = bsc_pkg::RC_CFG_RESET;

   scan_result_type due_results [$];
   scan_result_type seen_result;
   scan_result_type want_result;

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          error_count   = 0;
   int unsigned cycle_count   = 0;

   function automatic int procs_in_use();
      return (proc_count_cfg > N_PROC) ? N_PROC : int'(proc_count_cfg);
   endfunction

   function automatic int res_in_use();
      return (res_count_cfg > N_RES) ? N_RES : int'(res_count_cfg);
   endfunction

   function automatic int rand_amount();
      return $urandom_range(1) ? $urandom_range(1023) : $urandom_range(31);
   endfunction

   function automatic bit row_fits(input int row, input int rc_eff);
      int need;
      bit ok;
      ok = 1'b1;
      for (int col = 0; col < rc_eff; col++) begin
         need = int'(claim_shadow[row][col]) - int'(alloc_shadow[row][col]);
         if (int'(free_shadow[col]) < need) ok = 1'b0;
      end
      return ok;
   endfunction

   // walk the safe sequence and queue one result per pick plus the verdict
   task automatic run_safety_scan();
      int pc_eff, rc_eff, done_count, pick;
      bit finished [N_PROC];
      logic [bsc_pkg::FREE_W:0] total;
      pc_eff = procs_in_use();
      rc_eff = res_in_use();
      foreach (finished[i]) finished[i] = 1'b0;
      done_count = 0;
      pick = 0;
      while (done_count < pc_eff && pick >= 0) begin
         pick = -1;
         // descending walk leaves the lowest fitting row in pick
         for (int row = pc_eff - 1; row >= 0; row--) begin
            if (!finished[row] && row_fits(row, rc_eff)) pick = row;
         end
         if (pick >= 0) begin
            for (int col = 0; col < rc_eff; col++) begin
               total = free_shadow[col] + alloc_shadow[pick][col];
               free_shadow[col] = (total > bsc_pkg::FREE_LIMIT) ? bsc_pkg::FREE_LIMIT
                                                                : total[bsc_pkg::FREE_W-1:0];
               alloc_shadow[pick][col] = '0;
               claim_shadow[pick][col] = '0;
            end
            finished[pick] = 1'b1;
            done_count++;
            due_results.push_back('{bsc_pkg::PICK_W'(pick), 1'b0, 1'b0, 1'b0});
         end
      end
      due_results.push_back('{'0, 1'b1, done_count == pc_eff, 1'b1});
   endtask

   task automatic apply_item(input bsc_pkg::func_type f,
                             input logic [bsc_pkg::PROC_IDX_W-1:0] p,
                             input logic [bsc_pkg::RES_IDX_W-1:0] r,
                             input logic [bsc_pkg::AMOUNT_W-1:0] amt);
      case (f)
         bsc_pkg::FUNC_LOAD_ALLOC: alloc_shadow[p][r] = amt;
         bsc_pkg::FUNC_LOAD_CLAIM: claim_shadow[p][r] = amt;
         bsc_pkg::FUNC_LOAD_FREE:  free_shadow[r] = amt;
         bsc_pkg::FUNC_CHECK:      run_safety_scan();
         default: ;
      endcase
   endtask

   // valid stays high after the transaction; the next call or quiesce decides
   task automatic send_item(input bsc_pkg::func_type f, input int p, input int r,
                            input int amt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.func           <= f;
      req_bus.process_index  <= bsc_pkg::PROC_IDX_W'(p);
      req_bus.resource_index <= bsc_pkg::RES_IDX_W'(r);
      req_bus.amount         <= bsc_pkg::AMOUNT_W'(amt);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_item(f, bsc_pkg::PROC_IDX_W'(p), bsc_pkg::RES_IDX_W'(r), bsc_pkg::AMOUNT_W'(amt));
   endtask

   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic reconfigure(input int procs, input int res);
      quiesce();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= bsc_pkg::CSR_PROCESS_COUNT;
      csr_bus.data  <= bsc_pkg::CSR_DATA_W'(procs);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      proc_count_cfg = bsc_pkg::PC_CFG_W'(procs);
      csr_bus.index <= bsc_pkg::CSR_RESOURCE_COUNT;
      csr_bus.data  <= bsc_pkg::CSR_DATA_W'(res);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      res_count_cfg = bsc_pkg::RC_CFG_W'(res);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic rand_reconfigure();
      int procs, res;
      procs = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, N_PROC);
      res   = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(1, N_RES);
      reconfigure(procs, res);
   endtask

   // every entry gets written before any check can read it
   task automatic test_table_fill();
      for (int p = 0; p < N_PROC; p++) begin
         for (int r = 0; r < N_RES; r++) begin
            send_item(bsc_pkg::FUNC_LOAD_ALLOC, p, r, rand_amount());
            send_item(bsc_pkg::FUNC_LOAD_CLAIM, p, r, rand_amount());
         end
      end
      for (int r = 0; r < N_RES; r++) send_item(bsc_pkg::FUNC_LOAD_FREE, 0, r, rand_amount());
   endtask

   task automatic test_directed_cases();
      // no processes: immediate safe verdict
      reconfigure(0, N_RES);
      send_item(bsc_pkg::FUNC_CHECK, 0, 0, 0);
      // no resources: every process fits, longest result burst
      reconfigure(N_PROC, 0);
      send_item(bsc_pkg::FUNC_CHECK, 15, 7, 1023);
      // oversized counts act as the maximum
      reconfigure(31, 15);
      send_item(bsc_pkg::FUNC_CHECK, 0, 0, 0);
      // deadlock with nothing free
      reconfigure(2, 1);
      send_item(bsc_pkg::FUNC_LOAD_ALLOC, 0, 0, 0);
      send_item(bsc_pkg::FUNC_LOAD_CLAIM, 0, 0, 1023);
      send_item(bsc_pkg::FUNC_LOAD_ALLOC, 1, 0, 0);
      send_item(bsc_pkg::FUNC_LOAD_CLAIM, 1, 0, 1023);
      send_item(bsc_pkg::FUNC_LOAD_FREE, 0, 0, 0);
      send_item(bsc_pkg::FUNC_CHECK, 0, 0, 0);
      // need exactly equal to free
      send_item(bsc_pkg::FUNC_LOAD_FREE, 0, 0, 1023);
      send_item(bsc_pkg::FUNC_CHECK, 0, 0, 0);
      // negative need lets process 1 go first and release enough for process 0
      send_item(bsc_pkg::FUNC_LOAD_ALLOC, 1, 0, 1023);
      send_item(bsc_pkg::FUNC_LOAD_CLAIM, 1, 0, 0);
      send_item(bsc_pkg::FUNC_LOAD_ALLOC, 0, 0, 5);
      send_item(bsc_pkg::FUNC_LOAD_CLAIM, 0, 0, 1023);
      send_item(bsc_pkg::FUNC_LOAD_FREE, 0, 0, 1017);
      send_item(bsc_pkg::FUNC_CHECK, 0, 0, 0);
      // far corner of the tables
      reconfigure(N_PROC, N_RES);
      send_item(bsc_pkg::FUNC_LOAD_ALLOC, 15, 7, 1023);
      send_item(bsc_pkg::FUNC_LOAD_CLAIM, 15, 7, 1023);
      send_item(bsc_pkg::FUNC_CHECK, 0, 0, 0);
   endtask

   // repeated full allocations push free amount 0 past its ceiling
   task automatic test_free_saturation();
      reconfigure(N_PROC, 1);
      send_item(bsc_pkg::FUNC_LOAD_FREE, 0, 0, 1023);
      for (int p = 0; p < N_PROC; p++) send_item(bsc_pkg::FUNC_LOAD_CLAIM, p, 0, 0);
      repeat (4) begin
         for (int p = 0; p < N_PROC; p++) send_item(bsc_pkg::FUNC_LOAD_ALLOC, p, 0, 1023);
         send_item(bsc_pkg::FUNC_CHECK, 0, 0, 0);
      end
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_p);
      int sent, kind, n, pc_eff, rc_eff;
      bsc_pkg::func_type f;
      quiesce();
      send_idle_pct = send_pct;
      stall_pct     = stall_p;
      rand_reconfigure();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         kind = $urandom_range(9);
         pc_eff = procs_in_use();
         rc_eff = res_in_use();
         n = $urandom_range(1, 8);
         if (kind <= 6) begin
            // loads aimed at rows and columns in use, then a check
            for (int k = 0; k < n; k++) begin
               f = bsc_pkg::func_type'($urandom_range(2));
               send_item(f, (pc_eff > 0) ? $urandom_range(pc_eff - 1) : $urandom_range(15),
                         (rc_eff > 0) ? $urandom_range(rc_eff - 1) : $urandom_range(7),
                         rand_amount());
            end
            send_item(bsc_pkg::FUNC_CHECK, $urandom_range(15), $urandom_range(7),
                      $urandom_range(1023));
            sent += n + 1;
         end else if (kind <= 8) begin
            for (int k = 0; k < n / 2 + 1; k++) begin
               send_item(bsc_pkg::func_type'($urandom_range(3)), $urandom_range(15),
                         $urandom_range(7), $urandom_range(1023));
            end
            sent += n / 2 + 1;
         end else begin
            // sender holds until every result is back, then new counts
            rand_reconfigure();
         end
      end
   endtask

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_result = '{rsp_bus.picked_process, rsp_bus.is_verdict, rsp_bus.system_safe,
                         rsp_bus.last_of_run};
         if (due_results.size() == 0) begin
            error_count++;
            $display("%0t: result expected none actual %p", $time, seen_result);
         end else begin
            want_result = due_results.pop_front();
            report_field("picked_process", want_result.picked_process,
                         seen_result.picked_process);
            report_field("is_verdict", want_result.is_verdict, seen_result.is_verdict);
            report_field("system_safe", want_result.system_safe, seen_result.system_safe);
            report_field("last_of_run", want_result.last_of_run, seen_result.last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.func           <= bsc_pkg::FUNC_LOAD_ALLOC;
      req_bus.process_index  <= '0;
      req_bus.resource_index <= '0;
      req_bus.amount         <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= bsc_pkg::CSR_PROCESS_COUNT;
      csr_bus.data           <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_fill();
      test_directed_cases();
      test_free_saturation();
      test_random_traffic(0, 0);
      test_random_traffic(47, 0);
      test_random_traffic(0, 47);
      test_random_traffic(18, 18);

      // drain, then watch a little longer for stray transactions
      quiesce();
      repeat (4 * SETTLE) @(posedge clock);
      if (error_count == 0 && due_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
